FILE: hdl/quaternion_smallest_three_quantizer_defines.svh
// Assertion macros for the smallest-three quantizer.
`ifndef QUATERNION_SMALLEST_THREE_QUANTIZER_DEFINES_SVH
`define QUATERNION_SMALLEST_THREE_QUANTIZER_DEFINES_SVH

`ifndef SYNTH

`define SQT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define SQT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SQT_ASSERT_SAME(label, clk, rst, ante, cons)

`define SQT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/sqt_pkg.sv
`default_nettype none

package sqt_pkg;

   localparam int COMP_W                 = 16;
   localparam int NUM_COMP               = 4;
   localparam int NUM_REST               = 3;
   localparam int SMALL_W                = 15;
   localparam int COMPONENT_BITS_DEFAULT = 15;

   // sqrt(2)/2 in Q0.32
   localparam logic [31:0] HALF_SQRT2_Q32 = 32'd3037000500;
   localparam int          ROUND_POS      = 46;
   localparam int          FRAC_POS       = 47;
   localparam int          U_W            = 49;
   localparam int          SCALED_W       = 64;
   localparam int          RES_W          = SCALED_W - FRAC_POS;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [1:0]               comp_idx_type;
   typedef logic [SMALL_W-1:0]       small_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } pipe_load_type;

   localparam comp_idx_type REST_OF [NUM_COMP][NUM_REST] = '{
      '{2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd3},
      '{2'd0, 2'd1, 2'd2}
   };

endpackage

`default_nettype wire

FILE: hdl/quaternion_smallest_three_quantizer.sv
// Smallest-three quaternion quantizer.
// req channel: one beat carries a quaternion, four signed Q1.15 components
//   packed in req_tdata (x lowest, then y, z, w).
// rsp channel: one beat per request. rsp_tuser carries the index of the
//   largest-magnitude component and its sign; rsp_tdata carries the other
//   three components quantized to COMPONENT_BITS, in index order.
// Pipeline: a beat passes the multiply stage, the scale/round/clamp stage and
//   the merge/output register in order; rsp_tvalid rises once it is in the last.
// Throughput: one beat per cycle while rsp_tready stays high, set by the four pipelined quantizer lanes.
// Each stage holds its beat only while the next one is full and stalled, so bubbles are
//   squeezed out and a request is taken while a result waits on rsp_tready.
//   A stall of rsp_tready backs up at most three beats, then req_tready drops.
// Reset (synchronous) empties the pipeline; rsp_tvalid is low afterward.
`default_nettype none

`include "quaternion_smallest_three_quantizer_defines.svh"

module quaternion_smallest_three_quantizer
   import sqt_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // quat_x, quat_y, quat_z, quat_w
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // smallest_a, smallest_b, smallest_c, 3'b0
   output logic [2:0]       rsp_tuser    // largest_index, largest_negative
);

   logic                      v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                      ready1, ready2, ready3;
   pipe_load_type             load;
   comp_type                  comp [NUM_COMP];
   logic [COMPONENT_BITS-1:0] quant [NUM_COMP];
   comp_idx_type              idx2;
   logic                      neg2;
   comp_idx_type              largest_index;
   logic                      largest_negative;
   small_type                 smallest [NUM_REST];

   assign ready3 = !v3_ff || rsp_tready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign load.s1 = ready1;
   assign load.s2 = ready2;
   assign load.s3 = ready3;

   assign v1_in = ready1 ? req_tvalid : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         comp[i] = req_tdata[i*COMP_W +: COMP_W];
      end
   end

   for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
      sqt_lane #(
         .COMPONENT_BITS (COMPONENT_BITS)
      ) u_lane (
         .clock (clock),
         .load  (load),
         .comp  (comp[g]),
         .quant (quant[g])
      );
   end

   sqt_argmax u_argmax (
      .clock            (clock),
      .load             (load),
      .comp             (comp),
      .largest_index    (idx2),
      .largest_negative (neg2)
   );

   sqt_merge #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_merge (
      .clock            (clock),
      .load             (load),
      .idx              (idx2),
      .neg              (neg2),
      .quant            (quant),
      .largest_index    (largest_index),
      .largest_negative (largest_negative),
      .smallest         (smallest)
   );

   assign req_tready = ready1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {3'b000, smallest[2], smallest[1], smallest[0]};
   assign rsp_tuser  = {largest_negative, largest_index};

   `SQT_ASSERT_NEXT(a_s1_to_s2, clock, reset, v1_ff && ready2, v2_ff)
   `SQT_ASSERT_NEXT(a_s2_to_out, clock, reset, v2_ff && ready3, rsp_tvalid)
   `SQT_ASSERT_SAME(a_empty_takes, clock, reset, !v1_ff, req_tready)

endmodule

`default_nettype wire

FILE: hdl/sqt_lane.sv
`default_nettype none

module sqt_lane
   import sqt_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire pipe_load_type             load,
   input  wire comp_type                  comp,
   output logic [COMPONENT_BITS-1:0]      quant
);

   localparam logic signed [U_W-1:0] ROUND_U = U_W'(1) <<< ROUND_POS;
   localparam logic [SCALED_W-1:0]   ROUND_S = SCALED_W'(1) << ROUND_POS;
   localparam logic [RES_W-1:0]      FULL    = RES_W'((32'd1 << COMPONENT_BITS) - 32'd1);

   logic signed [U_W-1:0]       u_in, u_ff;
   logic [SCALED_W-1:0]         mag_u;
   logic [SCALED_W-1:0]         scaled;
   logic [RES_W-1:0]            res;
   logic [COMPONENT_BITS-1:0]   quant_in, quant_ff;

   // stage 1: u = q * sqrt(2)/2 + 1/2 in units of 2^-47
   assign u_in = comp * $signed({1'b0, HALF_SQRT2_Q32}) + ROUND_U;

   // stage 2: (2^B - 1) * u as shift and subtract, round half up, clamp
   assign mag_u  = {{(SCALED_W-U_W+1){1'b0}}, u_ff[U_W-2:0]};
   assign scaled = (mag_u << COMPONENT_BITS) - mag_u + ROUND_S;
   assign res    = scaled[SCALED_W-1:FRAC_POS];

   always_comb begin
      if (u_ff[U_W-1]) begin
         quant_in = '0;
      end else if (res > FULL) begin
         quant_in = FULL[COMPONENT_BITS-1:0];
      end else begin
         quant_in = res[COMPONENT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         u_ff <= u_in;
      end
      if (load.s2) begin
         quant_ff <= quant_in;
      end
   end

   assign quant = quant_ff;

endmodule

`default_nettype wire

FILE: hdl/sqt_argmax.sv
`default_nettype none

module sqt_argmax
   import sqt_pkg::*;
(
   input  wire logic          clock,
   input  wire pipe_load_type load,
   input  wire comp_type      comp [NUM_COMP],
   output comp_idx_type       largest_index,
   output logic               largest_negative
);

   logic [COMP_W:0]  mag [NUM_COMP];
   logic             pick_hi_lo, pick_hi_hi, pick_top;
   logic [COMP_W:0]  mag_lo, mag_hi;
   comp_idx_type     idx_in, idx_ff, idx2_ff;
   logic             neg_in, neg_ff, neg2_ff;

   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         mag[i] = comp[i][COMP_W-1] ? (COMP_W+1)'(-$signed({comp[i][COMP_W-1], comp[i]}))
                                    : {1'b0, comp[i]};
      end
   end

   // pairwise tree, strict greater keeps the lower index on ties
   assign pick_hi_lo = mag[1] > mag[0];
   assign pick_hi_hi = mag[3] > mag[2];
   assign mag_lo     = pick_hi_lo ? mag[1] : mag[0];
   assign mag_hi     = pick_hi_hi ? mag[3] : mag[2];
   assign pick_top   = mag_hi > mag_lo;

   assign idx_in = pick_top ? {1'b1, pick_hi_hi} : {1'b0, pick_hi_lo};
   assign neg_in = comp[idx_in][COMP_W-1];

   always_ff @(posedge clock) begin
      if (load.s1) begin
         idx_ff <= idx_in;
         neg_ff <= neg_in;
      end
      if (load.s2) begin
         idx2_ff <= idx_ff;
         neg2_ff <= neg_ff;
      end
   end

   assign largest_index    = idx2_ff;
   assign largest_negative = neg2_ff;

endmodule

`default_nettype wire

FILE: hdl/sqt_merge.sv
`default_nettype none

module sqt_merge
   import sqt_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire pipe_load_type         load,
   input  wire comp_idx_type          idx,
   input  wire logic                  neg,
   input  wire logic [COMPONENT_BITS-1:0] quant [NUM_COMP],
   output comp_idx_type               largest_index,
   output logic                       largest_negative,
   output small_type                  smallest [NUM_REST]
);

   comp_idx_type  idx_ff;
   logic          neg_ff;
   small_type     small_in [NUM_REST];
   small_type     small_ff [NUM_REST];

   always_comb begin
      for (int i = 0; i < NUM_REST; i++) begin
         small_in[i] = SMALL_W'(quant[REST_OF[idx][i]]);
      end
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         idx_ff   <= idx;
         neg_ff   <= neg;
         small_ff <= small_in;
      end
   end

   assign largest_index    = idx_ff;
   assign largest_negative = neg_ff;
   assign smallest         = small_ff;

endmodule

`default_nettype wire
